@@ src/rcg_pkg.sv @@
// Shared types and constants of the Roberts cross gradient block.
`default_nettype none
package rcg_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;
	localparam logic [12:0] SIZE_MIN     = 13'd2;
	localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

	// Root chain: one cell per result bit, 17-bit radicand
	localparam int ROOT_W     = 18;
	localparam int SQRT_CELLS = 9;

	typedef struct packed {
		logic              vld;
		logic [ROOT_W-1:0] rem;
		logic [ROOT_W-1:0] root;
		logic [11:0]       col;
		logic [11:0]       row;
	} cell_t;

endpackage
`default_nettype wire

@@ src/roberts_cross_gradient.sv @@
// Top level: streaming Roberts cross edge magnitude with a line store and root chain.
//
//  channel    signals                              direction  carries
//  -------    -----------------------------------  ---------  ---------------------------
//  pixel      pix_valid / pix_ready / pixel         in         grey pixel, raster order
//  gradient   grad_valid / grad_ready / gradient,   out        magnitude and window corner
//             out_col, out_row
//  config     cfg_valid / cfg_ready / cfg_index,    in         image_width (0), image_height (1)
//             cfg_data
//
// One pixel request is taken every clock while the result is not stalled; the line store, the squares stage and the
// nine-cell square root chain all advance together, one stage per clock.
// A pixel's result passes through s1, s2, s3 and then the nine cells, in that order.
// A stalled result freezes the whole chain, so pix_ready falls with it.
// Reset clears counters, window registers and valid bits; the line store is not cleared
// and each entry is read only after the row above wrote it. cfg_ready is always high.
`default_nettype none
module roberts_cross_gradient
	import rcg_pkg::*;
#(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pix_valid,
	output logic             pix_ready,
	input  wire logic [7:0]  pixel,
	output logic             grad_valid,
	input  wire logic        grad_ready,
	output logic [7:0]       gradient,
	output logic [11:0]      out_col,
	output logic [11:0]      out_row,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > 14) ? CW + 1 : 14;

	// Configuration
	logic [12:0] width_q, height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamped frame size
	logic [EW-1:0] w_raw, w_eff;
	logic [12:0]   h_eff;

	assign w_raw = EW'(width_q);

	always_comb begin
		if (w_raw < EW'(SIZE_MIN))
			w_eff = EW'(SIZE_MIN);
		else if (w_raw > EW'(MAX_WIDTH))
			w_eff = EW'(MAX_WIDTH);
		else
			w_eff = w_raw;
		if (height_q < SIZE_MIN)
			h_eff = SIZE_MIN;
		else if (height_q > HEIGHT_LIMIT)
			h_eff = HEIGHT_LIMIT;
		else
			h_eff = height_q;
	end

	// Handshake: whole chain moves when the output slot is free
	logic adv, accept;

	assign adv       = !grad_valid || grad_ready;
	assign pix_ready = adv;
	assign accept    = pix_valid && adv;

	// Position of the incoming pixel; stale counters after a resize are fixed up first
	logic [CW-1:0]    col_q, c, c_m1, col_d;
	logic [11:0]      row_q, r, r_m1, row_d;
	logic [12:0]      r_inc, r_a, r_b;
	logic [EW-1:0]    c_inc;
	logic [CW+11:0]   col_ext;
	logic             wrap_a, wrap_b, produce;

	always_comb begin
		wrap_a  = EW'(col_q) >= w_eff;
		c       = wrap_a ? '0 : col_q;
		r_inc   = {1'b0, row_q} + 13'd1;
		r_a     = wrap_a ? r_inc : {1'b0, row_q};
		r       = (r_a >= h_eff) ? 12'd0 : r_a[11:0];
		c_inc   = EW'(c) + EW'(1);
		wrap_b  = c_inc >= w_eff;
		r_b     = {1'b0, r} + 13'd1;
		col_d   = wrap_b ? '0 : c_inc[CW-1:0];
		row_d   = wrap_b ? ((r_b >= h_eff) ? 12'd0 : r_b[11:0]) : r;
		c_m1    = c - CW'(1);
		col_ext = {12'b0, c_m1};
		r_m1    = r - 12'd1;
		produce = (r != 12'd0) && (c != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// Line store: pixel directly above comes back from a registered read, in the cycle after the access
	logic [7:0] above;

	rcg_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line (
		.clk   (clk),
		.en    (accept),
		.addr  (c),
		.wdata (pixel),
		.rdata (above)
	);

	// s1: accepted pixel and its window corner
	logic        acc_s1, prod_s1;
	logic [7:0]  pix_s1;
	logic [11:0] col_s1, row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1  <= 1'b0;
			prod_s1 <= 1'b0;
		end else if (adv) begin
			acc_s1  <= accept;
			prod_s1 <= accept && produce;
			pix_s1  <= pixel;
			col_s1  <= col_ext[11:0];
			row_s1  <= r_m1;
		end
	end

	// s2: cross differences and their squares; left pixels shift on every request
	logic [7:0]         left_above_q, left_current_q;
	logic signed [8:0]  g1, g2;
	logic signed [17:0] p1, p2;
	logic               prod_s2;
	logic [15:0]        sq1_s2, sq2_s2;
	logic [11:0]        col_s2, row_s2;

	always_comb begin
		g1 = $signed({1'b0, left_above_q}) - $signed({1'b0, pix_s1});
		g2 = $signed({1'b0, left_current_q}) - $signed({1'b0, above});
		p1 = g1 * g1;
		p2 = g2 * g2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_above_q   <= 8'd0;
			left_current_q <= 8'd0;
			prod_s2        <= 1'b0;
		end else if (adv) begin
			if (acc_s1) begin
				left_above_q   <= above;
				left_current_q <= pix_s1;
			end
			prod_s2 <= prod_s1;
			sq1_s2  <= p1[15:0];
			sq2_s2  <= p2[15:0];
			col_s2  <= col_s1;
			row_s2  <= row_s1;
		end
	end

	// s3: sum of squares enters the root chain
	cell_t       chain [SQRT_CELLS+1];
	cell_t       s3_q;
	logic [16:0] sum;

	assign sum = {1'b0, sq1_s2} + {1'b0, sq2_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_q.vld <= 1'b0;
		end else if (adv) begin
			s3_q.vld  <= prod_s2;
			s3_q.rem  <= ROOT_W'(sum);
			s3_q.root <= '0;
			s3_q.col  <= col_s2;
			s3_q.row  <= row_s2;
		end
	end

	assign chain[0] = s3_q;

	// Cell i settles root bit SQRT_CELLS-1-i
	for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_cell
		rcg_sqrt_cell #(
			.BIT_POS (SQRT_CELLS - 1 - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	// Output: last cell is the result register; saturate to 8 bits
	assign grad_valid = chain[SQRT_CELLS].vld;
	assign gradient   = (chain[SQRT_CELLS].root > ROOT_W'(255)) ? 8'hFF
	                                                            : chain[SQRT_CELLS].root[7:0];
	assign out_col    = chain[SQRT_CELLS].col;
	assign out_row    = chain[SQRT_CELLS].row;

endmodule
`default_nettype wire

@@ src/rcg_line_store.sv @@
// One-row line store, read-first, registered read data.
`default_nettype none
module rcg_line_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] addr,
	input  wire logic [7:0]    wdata,
	output logic [7:0]         rdata
);

	logic [7:0] mem [DEPTH];

	// Same address read and written: the old pixel (row above) comes out
	always_ff @(posedge clk) begin
		if (en) begin
			rdata     <= mem[addr];
			mem[addr] <= wdata;
		end
	end

endmodule
`default_nettype wire

@@ src/rcg_sqrt_cell.sv @@
// One cell of the bit-serial square root chain: settles one root bit.
`default_nettype none
module rcg_sqrt_cell
	import rcg_pkg::*;
#(
	parameter int BIT_POS = 0
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire cell_t d,
	output cell_t      q
);

	localparam logic [ROOT_W-1:0] TRIAL_BIT = {{(ROOT_W-1){1'b0}}, 1'b1} << (2 * BIT_POS);

	logic [ROOT_W-1:0] trial;
	cell_t             nxt;

	always_comb begin
		trial = d.root + TRIAL_BIT;
		nxt   = d;
		if (d.rem >= trial) begin
			nxt.rem  = d.rem - trial;
			nxt.root = (d.root >> 1) + TRIAL_BIT;
		end else begin
			nxt.root = d.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.vld <= 1'b0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ src/rcg_checker.sv @@
// Port-level checks of the Roberts cross gradient block, bound to the top level.
`default_nettype none
module rcg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pix_valid,
	input wire logic        pix_ready,
	input wire logic        grad_valid,
	input wire logic        grad_ready,
	input wire logic [7:0]  gradient,
	input wire logic [11:0] out_col,
	input wire logic [11:0] out_row
);

	// A held result stops the chain, so no pixel may be taken meanwhile
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		grad_valid && !grad_ready |-> !pix_ready)
		else $error("pixel taken while result stalled");

	// With the output slot free, an offered pixel is taken at once
	a_free_slot_takes: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && (!grad_valid || grad_ready) |-> pix_ready)
		else $error("pixel refused with output slot free");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		grad_valid && !grad_ready |=> grad_valid && $stable(gradient)
			&& $stable(out_col) && $stable(out_row))
		else $error("stalled result changed");

	// Window corner never sits on a row wrapped below zero
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		grad_valid |-> out_row != 12'hFFF)
		else $error("result row out of range");

	// Nothing comes out straight after reset
	a_quiet_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !grad_valid)
		else $error("result right after reset");

endmodule

bind roberts_cross_gradient rcg_checker u_rcg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_valid  (pix_valid),
	.pix_ready  (pix_ready),
	.grad_valid (grad_valid),
	.grad_ready (grad_ready),
	.gradient   (gradient),
	.out_col    (out_col),
	.out_row    (out_row)
);
`default_nettype wire
